// ----- src/framed_command_responder_defines.svh -----
// assertion helpers for the file that checks internal behaviour
`ifndef FRAMED_COMMAND_RESPONDER_DEFINES_SVH
`define FRAMED_COMMAND_RESPONDER_DEFINES_SVH

// same-cycle implication, ignored while reset is held
`define FCR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, ignored while reset is held
`define FCR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- src/fcr_pkg.sv -----
package fcr_pkg;

    // packet and reply framing
    localparam int PACKET_BYTES = 8;
    localparam int COUNT_W      = $clog2(PACKET_BYTES);
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    // marker and code bytes
    localparam logic [7:0] MK_BEGIN   = 8'hFF;
    localparam logic [7:0] MK_END     = 8'hAF;
    localparam logic [7:0] CMD_START  = 8'h65;
    localparam logic [7:0] CMD_STOP   = 8'h72;
    localparam logic [7:0] CODE_SYN   = 8'hEE;
    localparam logic [7:0] CODE_ACK   = 8'hAE;
    localparam logic [7:0] CODE_EMPTY = 8'h00;
    localparam logic [7:0] CODE_ERR   = 8'hDD;
    localparam logic [7:0] ERR_CMD    = 8'h69;
    localparam logic [7:0] ERR_ZONE   = 8'h6F;
    localparam logic [7:0] ERR_DUR    = 8'h70;

    // input operations
    localparam logic OP_BYTE    = 1'b0;
    localparam logic OP_TIMEOUT = 1'b1;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ZONE     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DURATION = 1'b1;

    localparam logic [7:0] MAX_ZONE_RST     = 8'd8;
    localparam logic [7:0] MAX_DURATION_RST = 8'd60;

    typedef struct packed {
        logic       operation;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       last_byte;
    } t_out_item;

    // one reply waiting to be serialised
    typedef struct packed {
        logic [7:0] id;
        logic [7:0] r1;
        logic [7:0] r2;
        logic [7:0] ck_lo;
        logic [7:0] ck_hi;
    } t_reply;

    // position within a reply frame
    typedef enum logic [2:0] {
        POS_BEGIN,
        POS_ID,
        POS_R1,
        POS_R2,
        POS_CK_LO,
        POS_CK_HI,
        POS_END
    } t_reply_pos;

    // queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // one step of a modulo-255 running sum
    function automatic logic [7:0] mod255_add(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= 9'd255) begin
            s = s - 9'd255;
        end
        return s[7:0];
    endfunction

endpackage

// ----- src/framed_command_responder.sv -----
// Framed command responder.
// Request channel: i_in_valid / o_in_stall with i_in_data (operation, rx_byte).
// One request per cycle unless stalled; a timeout clears a partial packet.
// Every eighth byte closes a packet, which is checked for markers and
// checksum and may change session state and queue one seven-byte reply.
// Reply channel: o_out_valid / i_out_stall with o_out_data; last_byte marks
// the end marker of each reply.
// A closing byte's reply goes to the reply queue, then byte by byte to the
// serialiser's output register, one a cycle while the receiver does not
// stall. Throughput is one request per cycle while o_in_stall is low, and
// one reply byte per cycle, set by the output register of the serialiser.
// A two-entry reply queue sits between classifier and serialiser; while it
// is full, o_in_stall is high. A stall on the reply channel holds the
// current byte and, once the queue fills, backs up into the request channel.
// Config writes (i_cfg_valid, always ready) set max_zone and max_duration.
// Reset clears the byte count, the session id and the connected flag and
// restores max_zone to 8 and max_duration to 60; no clearing pass is needed.
`include "framed_command_responder_defines.svh"

module framed_command_responder (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  fcr_pkg::t_in_item                   i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output fcr_pkg::t_out_item                  o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [fcr_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [7:0]                          i_cfg_data
);
    import fcr_pkg::*;

    logic [7:0] r_zone_max, r_dur_max;
    t_q_status  w_q_status;
    t_reply     w_push_data, w_head;
    logic       w_push, w_pop;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zone_max <= MAX_ZONE_RST;
            r_dur_max  <= MAX_DURATION_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_MAX_ZONE) begin
                r_zone_max <= i_cfg_data;
            end
            if (i_cfg_index == CFG_MAX_DURATION) begin
                r_dur_max <= i_cfg_data;
            end
        end
    end

    // classifier
    fcr_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_in_valid),
        .o_stall        (o_in_stall),
        .i_item         (i_in_data),
        .i_max_zone     (r_zone_max),
        .i_max_duration (r_dur_max),
        .i_q_status     (w_q_status),
        .o_push         (w_push),
        .o_reply        (w_push_data)
    );

    // reply queue
    fcr_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_data   (w_push_data),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_status (w_q_status)
    );

    // frame serialiser
    fcr_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (w_head),
        .i_q_status (w_q_status),
        .o_pop      (w_pop),
        .o_valid    (o_out_valid),
        .i_stall    (i_out_stall),
        .o_item     (o_out_data)
    );

    // checks
    `FCR_ASSERT_NOW(a_no_push_when_full, i_clk, i_rst_n, w_push, !w_q_status.full)
    `FCR_ASSERT_NOW(a_no_pop_when_empty, i_clk, i_rst_n, w_pop, !w_q_status.empty)
    `FCR_ASSERT_NOW(a_last_is_end_marker, i_clk, i_rst_n,
        o_out_valid && o_out_data.last_byte, o_out_data.tx_byte == MK_END)
    `FCR_ASSERT_NEXT(a_stalled_reply_held, i_clk, i_rst_n,
        o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data))

endmodule

// ----- src/fcr_front.sv -----
module fcr_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  fcr_pkg::t_in_item i_item,
    input  logic [7:0]        i_max_zone,
    input  logic [7:0]        i_max_duration,
    input  fcr_pkg::t_q_status i_q_status,
    output logic              o_push,
    output fcr_pkg::t_reply   o_reply
);
    import fcr_pkg::*;

    logic [COUNT_W-1:0] r_count, n_count;
    logic [7:0]         r_pkt [PACKET_BYTES-1];
    logic [7:0]         r_f1, r_f2, n_f1, n_f2;
    logic [7:0]         r_p1, r_p2, n_p1, n_p2;
    logic [7:0]         r_sid, n_sid;
    logic               r_conn, n_conn;
    logic               w_accept;
    logic               w_byte_in;
    logic               w_last;
    logic [7:0]         w_b;
    logic               w_frame_ok;
    logic               w_emit;
    logic [7:0]         w_r1, w_r2;

    // hold off new bytes while the reply queue is full
    assign o_stall   = i_q_status.full;
    assign w_accept  = i_valid && !o_stall;
    assign w_byte_in = w_accept && (i_item.operation == OP_BYTE);
    assign w_b       = i_item.rx_byte;
    assign w_last    = (r_count == COUNT_W'(PACKET_BYTES - 1));

    // running fletcher sums: whole packet, and bytes 1 to 4
    always_comb begin
        n_f1 = mod255_add((r_count == '0) ? 8'd0 : r_f1, w_b);
        n_f2 = mod255_add((r_count == '0) ? 8'd0 : r_f2, n_f1);
        n_p1 = mod255_add((r_count == COUNT_W'(1)) ? 8'd0 : r_p1, w_b);
        n_p2 = mod255_add((r_count == COUNT_W'(1)) ? 8'd0 : r_p2, n_p1);
    end

    // byte counter and packet capture
    always_comb begin
        n_count = r_count;
        if (w_accept) begin
            if (i_item.operation == OP_TIMEOUT || w_last) begin
                n_count = '0;
            end else begin
                n_count = r_count + COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_byte_in) begin
            r_f1 <= n_f1;
            r_f2 <= n_f2;
            if (r_count >= COUNT_W'(1) && r_count <= COUNT_W'(4)) begin
                r_p1 <= n_p1;
                r_p2 <= n_p2;
            end
            if (!w_last) begin
                r_pkt[r_count] <= w_b;
            end
        end
    end

    // packet classification on the closing byte
    assign w_frame_ok = (r_pkt[0] == MK_BEGIN) && (w_b == MK_END)
                     && (r_p2 == r_pkt[5]) && (r_p1 == r_pkt[6]);

    always_comb begin
        n_sid  = r_sid;
        n_conn = r_conn;
        w_emit = 1'b0;
        w_r1   = CODE_ACK;
        w_r2   = CODE_EMPTY;
        if (w_byte_in && w_last && w_frame_ok) begin
            if (r_pkt[2] == CODE_SYN) begin
                n_sid  = r_pkt[1];
                n_conn = 1'b0;
                w_emit = 1'b1;
                w_r1   = CODE_SYN;
                w_r2   = CODE_ACK;
            end else if (r_pkt[2] == CODE_ACK && r_pkt[1] == r_sid && !r_conn) begin
                n_conn = 1'b1;
            end else if (r_conn && r_pkt[1] == r_sid) begin
                w_emit = 1'b1;
                if (r_pkt[2] == CMD_START) begin
                    if (r_pkt[3] == 8'd0 || r_pkt[3] > i_max_zone) begin
                        w_r1 = CODE_ERR;
                        w_r2 = ERR_ZONE;
                    end else if (r_pkt[4] == 8'd0 || r_pkt[4] > i_max_duration) begin
                        w_r1 = CODE_ERR;
                        w_r2 = ERR_DUR;
                    end
                end else if (r_pkt[2] != CMD_STOP) begin
                    w_r1 = CODE_ERR;
                    w_r2 = ERR_CMD;
                end
            end
        end
    end

    // session state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sid  <= 8'd0;
            r_conn <= 1'b0;
        end else begin
            r_sid  <= n_sid;
            r_conn <= n_conn;
        end
    end

    // reply descriptor towards the queue
    assign o_push        = w_emit;
    assign o_reply.id    = n_sid;
    assign o_reply.r1    = w_r1;
    assign o_reply.r2    = w_r2;
    assign o_reply.ck_lo = n_f1;
    assign o_reply.ck_hi = n_f2;

endmodule

// ----- src/fcr_queue.sv -----
module fcr_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  fcr_pkg::t_reply    i_data,
    input  logic               i_pop,
    output fcr_pkg::t_reply    o_head,
    output fcr_pkg::t_q_status o_status
);
    import fcr_pkg::*;

    t_reply              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr, r_rd;
    logic [QCNT_W-1:0]   r_cnt, n_cnt;
    logic                w_push, w_pop;

    assign o_status.full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_status.empty = (r_cnt == '0);
    assign w_push = i_push && !o_status.full;
    assign w_pop  = i_pop && !o_status.empty;
    assign o_head = r_mem[r_rd];

    // occupancy
    always_comb begin
        n_cnt = r_cnt;
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + QCNT_W'(1);
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - QCNT_W'(1);
        end
    end

    // pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (w_push) begin
                r_wr <= (r_wr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + QPTR_W'(1);
            end
            if (w_pop) begin
                r_rd <= (r_rd == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + QPTR_W'(1);
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ----- src/fcr_back.sv -----
module fcr_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  fcr_pkg::t_reply    i_head,
    input  fcr_pkg::t_q_status i_q_status,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_stall,
    output fcr_pkg::t_out_item o_item
);
    import fcr_pkg::*;

    t_reply_pos r_pos, n_pos;
    logic       r_valid, n_valid;
    t_out_item  r_item, n_item;
    logic       w_load;
    logic       w_step;

    // the output register takes a byte when empty or being drained
    assign w_load = !r_valid || !i_stall;
    assign w_step = w_load && !i_q_status.empty;

    // frame sequencer and byte select
    always_comb begin
        n_pos           = r_pos;
        n_valid         = r_valid;
        n_item          = r_item;
        o_pop           = 1'b0;
        if (w_load) begin
            n_valid = w_step;
        end
        n_item.last_byte = 1'b0;
        case (r_pos)
            POS_BEGIN: n_item.tx_byte = MK_BEGIN;
            POS_ID:    n_item.tx_byte = i_head.id;
            POS_R1:    n_item.tx_byte = i_head.r1;
            POS_R2:    n_item.tx_byte = i_head.r2;
            POS_CK_LO: n_item.tx_byte = i_head.ck_lo;
            POS_CK_HI: n_item.tx_byte = i_head.ck_hi;
            POS_END: begin
                n_item.tx_byte   = MK_END;
                n_item.last_byte = 1'b1;
            end
            default:   n_item.tx_byte = MK_END;
        endcase
        if (!w_step) begin
            n_item = r_item;
        end else if (r_pos == POS_END) begin
            n_pos = POS_BEGIN;
            o_pop = 1'b1;
        end else begin
            n_pos = t_reply_pos'(r_pos + 3'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= POS_BEGIN;
            r_valid <= 1'b0;
        end else begin
            r_pos   <= n_pos;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule
